// ===== design/bpa_pkg.sv =====
`timescale 1ns / 1ps

package bpa_pkg;

    // bitmap geometry
    localparam int WORD_BITS  = 32;
    localparam int WORD_COUNT = 1024;
    localparam int LOG_WB     = $clog2(WORD_BITS);
    localparam int WORD_AW    = $clog2(WORD_COUNT);
    localparam int HINT_W     = WORD_AW + 1;
    localparam int ENT_W      = 16;
    localparam int POS_W      = 15;
    localparam int LEN_W      = 16;
    localparam int RUNB_W     = LOG_WB + 1;

    localparam logic [ENT_W-1:0]     ENT_MAX  = ENT_W'(WORD_COUNT * WORD_BITS);
    localparam logic [WORD_BITS-1:0] ALL_ONES = 32'hFFFF_FFFF;
    localparam logic [WORD_BITS-1:0] ALL_ZERO = 32'h0000_0000;

    // configuration register index
    localparam logic REG_TRACKED = 1'b0;

    // request kinds
    localparam logic [1:0] MODE_FREE = 2'd0;
    localparam logic [1:0] MODE_USED = 2'd1;
    localparam logic [1:0] MODE_FIND = 2'd2;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_ZERO     = 3'd1,
        ST_BOUNDS   = 3'd2,
        ST_NOFIT    = 3'd3,
        ST_CONFLICT = 3'd4
    } t_status;

    typedef enum logic [4:0] {
        S_CLR  = 5'b00001,
        S_IDLE = 5'b00010,
        S_MARK = 5'b00100,
        S_FIND = 5'b01000,
        S_DONE = 5'b10000
    } t_state;

endpackage

// ===== design/bitmap_page_allocator_core.sv =====
`timescale 1ns / 1ps

// flow: a mark reads and writes back each spanned word, a find passes each scanned
// word through scan stages a and b, early rejects skip both; all end in the output register
// throughput: one request in flight; the bitmap memory serves one word read and one
// word write per cycle, so marks and scans move one word per cycle
// reset: synchronous, active low; a clearing pass then writes 1024 words to zero,
// during which no request is taken (configuration writes still are)
module bitmap_page_allocator_core
    import bpa_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // request channel
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [1:0]           i_mode,
    input  logic [POS_W-1:0]     i_position,
    input  logic [LEN_W-1:0]     i_run_length,
    // result channel
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [2:0]           o_status,
    output logic [POS_W-1:0]     o_found_position,
    // configuration port
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [2:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);

    t_state r_state;

    logic [ENT_W-1:0]     r_tracked;
    logic [WORD_BITS-1:0] mem [WORD_COUNT];
    logic [WORD_BITS-1:0] r_rdata;

    logic [WORD_AW-1:0]   r_clr;
    logic [HINT_W-1:0]    r_hint;

    // request context
    logic                 r_used;
    logic [LEN_W-1:0]     r_len;
    logic [LOG_WB-1:0]    r_lo;
    logic [LOG_WB-1:0]    r_hi;
    logic [WORD_AW-1:0]   r_first;
    logic [WORD_AW-1:0]   r_last;
    logic                 r_conf;

    // read issue and pipeline
    logic                 r_iss_on;
    logic [WORD_AW-1:0]   r_iss_w;
    logic                 r_rd_v;
    logic [WORD_AW-1:0]   r_rd_w;

    // scan stage a
    logic                 r_a_v;
    logic [WORD_AW-1:0]   r_a_w;
    logic [WORD_BITS-1:0] r_a_win;
    logic [WORD_BITS-1:0] r_a_pre;
    logic                 r_a_full;
    logic                 r_a_empty;
    logic [RUNB_W-1:0]    r_a_tail;

    // scan state
    logic [LEN_W-1:0]     r_run;
    logic                 r_all_used;

    // pending result and output register
    t_status              r_res_st;
    logic [POS_W-1:0]     r_res_found;
    logic                 r_out_valid;
    logic [2:0]           r_status;
    logic [POS_W-1:0]     r_found;

    // effective entries and word count
    logic [ENT_W-1:0]     ent;
    logic [HINT_W-1:0]    wc;
    logic [ENT_W:0]       ent_rnd;

    always_comb begin
        ent     = (r_tracked > ENT_MAX) ? ENT_MAX : r_tracked;
        ent_rnd = {1'b0, ent} + (ENT_W+1)'(WORD_BITS - 1);
        wc      = HINT_W'(ent_rnd >> LOG_WB);
    end

    // configuration port
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_TRACKED) ? {16'd0, r_tracked} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tracked <= ENT_MAX;
        end else if (psel && penable && pwrite && paddr[2] == REG_TRACKED) begin
            r_tracked <= pwdata[ENT_W-1:0];
        end
    end

    // request decode at transfer
    logic                 acc;
    logic [LEN_W:0]       req_top;
    logic [LEN_W:0]       req_end;

    always_comb begin
        acc     = i_in_valid && (r_state == S_IDLE);
        req_top = {2'b00, i_position} + {1'b0, i_run_length};
        req_end = req_top - (LEN_W+1)'(1);
    end

    // mark: per word update
    logic [LOG_WB-1:0]    mk_lo;
    logic [LOG_WB-1:0]    mk_hi;
    logic [WORD_BITS-1:0] mk_mask;
    logic                 mk_conf;
    logic [WORD_BITS-1:0] mk_word;
    logic                 mk_last;

    always_comb begin
        mk_lo   = (r_rd_w == r_first) ? r_lo : '0;
        mk_hi   = (r_rd_w == r_last) ? r_hi : LOG_WB'(WORD_BITS - 1);
        mk_mask = (ALL_ONES << mk_lo) & (ALL_ONES >> (LOG_WB'(WORD_BITS - 1) - mk_hi));
        mk_conf = r_used ? ((r_rdata & mk_mask) != ALL_ZERO)
                         : ((~r_rdata & mk_mask) != ALL_ZERO);
        mk_word = r_used ? (r_rdata | mk_mask) : (r_rdata & ~mk_mask);
        mk_last = (r_rd_w == r_last);
    end

    // scan stage a: mask tail pages, free-window and prefix vectors
    logic [WORD_BITS-1:0] sa_word;
    logic [WORD_BITS-1:0] sa_free;
    logic [WORD_BITS-1:0] sa_span [LOG_WB+1];
    logic [WORD_BITS-1:0] sa_win;
    logic [WORD_BITS-1:0] sa_pre;
    logic [RUNB_W-1:0]    sa_tail;
    logic [LOG_WB-1:0]    sa_off;

    always_comb begin
        sa_word = r_rdata;
        if ({1'b0, r_rd_w} == ent[ENT_W-1:LOG_WB]) begin
            sa_word = r_rdata | (ALL_ONES << ent[LOG_WB-1:0]);
        end
        sa_free    = ~sa_word;
        // span k: 2^k free pages end at this bit
        sa_span[0] = sa_free;
        for (int k = 0; k < LOG_WB; k++) begin
            sa_span[k+1] = sa_span[k] & (sa_span[k] << (1 << k));
        end
        // window of run_length free pages, built from binary chunks
        sa_win = ALL_ONES;
        for (int k = 0; k <= LOG_WB; k++) begin
            sa_off = LOG_WB'(r_len[LOG_WB-1:0] & LOG_WB'((1 << k) - 1));
            if (r_len[k]) begin
                sa_win = sa_win & (sa_span[k] << sa_off);
            end
        end
        // pages from bit zero up to each bit are all free
        for (int b = 0; b < WORD_BITS; b++) begin
            sa_pre[b] = ((sa_word & (ALL_ONES >> (WORD_BITS - 1 - b))) == ALL_ZERO);
        end
        // free pages at the top of the word
        sa_tail = RUNB_W'(WORD_BITS);
        for (int b = 0; b < WORD_BITS; b++) begin
            if (sa_word[b]) begin
                sa_tail = RUNB_W'(WORD_BITS - 1 - b);
            end
        end
    end

    // scan stage b: join with carried run, pick the first fit
    logic [LEN_W:0]       sb_need;
    logic                 sb_short;
    logic [WORD_BITS-1:0] sb_hit;
    logic                 sb_any;
    logic [LOG_WB-1:0]    sb_sel;
    logic [LEN_W-1:0]     sb_start;
    logic                 sb_end;

    always_comb begin
        sb_need  = {1'b0, r_len} - {1'b0, r_run};
        sb_short = (r_len <= LEN_W'(WORD_BITS));
        for (int b = 0; b < WORD_BITS; b++) begin
            sb_hit[b] = (sb_short && r_a_win[b])
                     || (r_a_pre[b] && ((LEN_W+1)'(b + 1) >= sb_need));
        end
        sb_any = (sb_hit != ALL_ZERO);
        sb_sel = '0;
        for (int b = WORD_BITS - 1; b >= 0; b--) begin
            if (sb_hit[b]) begin
                sb_sel = LOG_WB'(b);
            end
        end
        sb_start = LEN_W'({r_a_w, sb_sel}) + LEN_W'(1) - r_len;
        sb_end   = ({1'b0, r_a_w} == wc - HINT_W'(1));
    end

    // memory port selection
    logic                 mem_we;
    logic [WORD_AW-1:0]   mem_wa;
    logic [WORD_BITS-1:0] mem_wd;
    logic                 mem_re;

    always_comb begin
        mem_we = 1'b0;
        mem_wa = r_rd_w;
        mem_wd = mk_word;
        if (r_state == S_CLR) begin
            mem_we = 1'b1;
            mem_wa = r_clr;
            mem_wd = ALL_ZERO;
        end else if (r_state == S_MARK && r_rd_v) begin
            mem_we = 1'b1;
        end
        mem_re = r_iss_on && (r_state == S_MARK || r_state == S_FIND);
    end

    // bitmap memory
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        if (mem_re) begin
            r_rdata <= mem[r_iss_w];
        end
    end

    // scan stage a register
    always_ff @(posedge i_clk) begin
        r_a_w     <= r_rd_w;
        r_a_win   <= sa_win;
        r_a_pre   <= sa_pre;
        r_a_full  <= (sa_word == ALL_ONES);
        r_a_empty <= (sa_word == ALL_ZERO);
        r_a_tail  <= sa_tail;
        r_rd_w    <= r_iss_w;
    end

    // control next values
    t_state               n_state;
    logic [WORD_AW-1:0]   n_clr;
    logic [HINT_W-1:0]    n_hint;
    logic                 n_iss_on;
    logic [WORD_AW-1:0]   n_iss_w;
    logic                 n_rd_v;
    logic                 n_a_v;
    logic                 n_out_valid;
    logic                 n_used;
    logic [LEN_W-1:0]     n_len;
    logic [LOG_WB-1:0]    n_lo;
    logic [LOG_WB-1:0]    n_hi;
    logic [WORD_AW-1:0]   n_first;
    logic [WORD_AW-1:0]   n_last;
    logic                 n_conf;
    logic [LEN_W-1:0]     n_run;
    logic                 n_all_used;
    t_status              n_res_st;
    logic [POS_W-1:0]     n_res_found;

    always_comb begin
        n_state     = r_state;
        n_clr       = r_clr;
        n_hint      = r_hint;
        n_iss_on    = r_iss_on;
        n_iss_w     = r_iss_w;
        n_rd_v      = mem_re;
        n_a_v       = 1'b0;
        n_out_valid = r_out_valid;
        n_used      = r_used;
        n_len       = r_len;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_first     = r_first;
        n_last      = r_last;
        n_conf      = r_conf;
        n_run       = r_run;
        n_all_used  = r_all_used;
        n_res_st    = r_res_st;
        n_res_found = r_res_found;

        // read issue, one word per cycle
        if (mem_re) begin
            n_iss_w = r_iss_w + WORD_AW'(1);
            if (r_iss_w == r_last) begin
                n_iss_on = 1'b0;
            end
        end

        // output register drains on transfer
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_CLR: begin
                n_clr = r_clr + WORD_AW'(1);
                if (r_clr == WORD_AW'(WORD_COUNT - 1)) begin
                    n_state = S_IDLE;
                end
            end

            S_IDLE: begin
                if (acc) begin
                    n_used      = (i_mode == MODE_USED);
                    n_len       = i_run_length;
                    n_lo        = i_position[LOG_WB-1:0];
                    n_hi        = req_end[LOG_WB-1:0];
                    n_first     = i_position[POS_W-1:LOG_WB];
                    n_conf      = 1'b0;
                    n_run       = '0;
                    n_all_used  = 1'b1;
                    n_res_found = '0;
                    n_res_st    = ST_OK;
                    n_state     = S_DONE;
                    if (i_mode == MODE_FREE || i_mode == MODE_USED) begin
                        if (i_run_length == '0) begin
                            n_res_st = ST_ZERO;
                        end else if (req_top > {1'b0, ent}) begin
                            n_res_st = ST_BOUNDS;
                        end else begin
                            n_iss_w  = i_position[POS_W-1:LOG_WB];
                            n_last   = req_end[POS_W-1:LOG_WB];
                            n_iss_on = 1'b1;
                            n_state  = S_MARK;
                        end
                    end else if (i_mode == MODE_FIND) begin
                        if (i_run_length == '0) begin
                            n_res_st = ST_ZERO;
                        end else if (r_hint >= wc) begin
                            n_res_st = ST_NOFIT;
                        end else begin
                            n_iss_w  = r_hint[WORD_AW-1:0];
                            n_last   = WORD_AW'(wc - HINT_W'(1));
                            n_iss_on = 1'b1;
                            n_state  = S_FIND;
                        end
                    end
                end
            end

            S_MARK: begin
                if (r_rd_v) begin
                    n_conf = r_conf | mk_conf;
                    if (mk_last) begin
                        n_res_st = (r_conf || mk_conf) ? ST_CONFLICT : ST_OK;
                        // freeing lowers the first-fit hint
                        if (!r_used && r_hint > {1'b0, r_first}) begin
                            n_hint = {1'b0, r_first};
                        end
                        n_state = S_DONE;
                    end
                end
            end

            S_FIND: begin
                n_a_v = r_rd_v;
                if (r_a_v) begin
                    if (sb_any) begin
                        n_res_st    = ST_OK;
                        n_res_found = sb_start[POS_W-1:0];
                        n_all_used  = 1'b0;
                    end else begin
                        if (r_a_full) begin
                            n_run = '0;
                            // hint follows the leading run of fully used words
                            if (r_all_used) begin
                                n_hint = {1'b0, r_a_w} + HINT_W'(1);
                            end
                        end else begin
                            n_all_used = 1'b0;
                            n_run = r_a_empty ? (r_run + LEN_W'(WORD_BITS))
                                              : LEN_W'(r_a_tail);
                        end
                        n_res_st = ST_NOFIT;
                    end
                    if (sb_any || sb_end) begin
                        n_iss_on = 1'b0;
                        n_rd_v   = 1'b0;
                        n_a_v    = 1'b0;
                        n_state  = S_DONE;
                    end
                end
            end

            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_clr       <= '0;
            r_hint      <= '0;
            r_iss_on    <= 1'b0;
            r_rd_v      <= 1'b0;
            r_a_v       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_hint      <= n_hint;
            r_iss_on    <= n_iss_on;
            r_rd_v      <= n_rd_v;
            r_a_v       <= n_a_v;
            r_out_valid <= n_out_valid;
            r_iss_w     <= n_iss_w;
            r_used      <= n_used;
            r_len       <= n_len;
            r_lo        <= n_lo;
            r_hi        <= n_hi;
            r_first     <= n_first;
            r_last      <= n_last;
            r_conf      <= n_conf;
            r_run       <= n_run;
            r_all_used  <= n_all_used;
            r_res_st    <= n_res_st;
            r_res_found <= n_res_found;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE && (!r_out_valid || i_out_ready)) begin
            r_status <= r_res_st;
            r_found  <= r_res_found;
        end
    end

    assign o_in_ready       = (r_state == S_IDLE);
    assign o_out_valid      = r_out_valid;
    assign o_status         = r_status;
    assign o_found_position = r_found;

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
    import bpa_pkg::*;

    localparam real         CLK_HALF     = 1.0;
    localparam int          STALL_LIMIT  = 8000;
    localparam int          PHASES       = 8;
    localparam int          PHASE_ITEMS  = 110;
    localparam logic [1:0]  MODE_UNDEF   = 2'd3;
    localparam logic [2:0]  TRACKED_ADDR = 3'(4 * int'(REG_TRACKED));
    localparam int          PHASE_PAGES [PHASES] = '{1000, 0, 1, 65535, 33, 4096, 0, 32768};

    typedef struct {
        t_status          status;
        logic [POS_W-1:0] found;
    } t_result;

    // bitmap predictor plus queue of outstanding results
    class alloc_scoreboard;
        logic [WORD_BITS-1:0] page_map [WORD_COUNT];
        int unsigned          hint_word;
        int unsigned          tracked;
        int unsigned          mismatches;
        t_result              pending_results [$];

        function new();
            foreach (page_map[i])
                page_map[i] = ALL_ZERO;
            hint_word  = 0;
            tracked    = 32768;
            mismatches = 0;
        endfunction

        function void set_tracked(int unsigned value);
            tracked = value;
        endfunction

        function int unsigned pending();
            return pending_results.size();
        endfunction

        // register value saturated to the bitmap capacity
        function int unsigned live_pages();
            return (tracked > WORD_COUNT * WORD_BITS) ? WORD_COUNT * WORD_BITS : tracked;
        endfunction

        function t_status mark_run(int unsigned pos, int unsigned len, bit used);
            int unsigned ent;
            int unsigned p;
            bit          clash;
            ent   = live_pages();
            clash = 1'b0;
            if (len == 0)
                return ST_ZERO;
            if (pos + len > ent)
                return ST_BOUNDS;
            for (p = pos; p < pos + len; p++) begin
                if (page_map[p / WORD_BITS][p % WORD_BITS] == used)
                    clash = 1'b1;
                page_map[p / WORD_BITS][p % WORD_BITS] = used;
            end
            // freeing pulls the first-fit hint back
            if (!used && hint_word > pos / WORD_BITS)
                hint_word = pos / WORD_BITS;
            return clash ? ST_CONFLICT : ST_OK;
        endfunction

        function t_status find_run(int unsigned len, output int unsigned start);
            int unsigned          ent;
            int unsigned          words;
            int unsigned          w;
            int unsigned          b;
            int unsigned          run;
            bit                   only_full;
            logic [WORD_BITS-1:0] word;
            ent       = live_pages();
            words     = (ent + WORD_BITS - 1) / WORD_BITS;
            run       = 0;
            only_full = 1'b1;
            start     = 0;
            if (len == 0)
                return ST_ZERO;
            for (w = hint_word; w < words; w++) begin
                word = page_map[w];
                // pages past the tracked range look used
                for (b = 0; b < WORD_BITS; b++)
                    if (w * WORD_BITS + b >= ent)
                        word[b] = 1'b1;
                if (word == ALL_ONES) begin
                    run = 0;
                    if (only_full && hint_word < w + 1)
                        hint_word = w + 1;
                    continue;
                end
                only_full = 1'b0;
                for (b = 0; b < WORD_BITS; b++) begin
                    if (word[b]) begin
                        run = 0;
                    end else begin
                        run++;
                        if (run >= len) begin
                            start = w * WORD_BITS + b + 1 - run;
                            return ST_OK;
                        end
                    end
                end
            end
            return ST_NOFIT;
        endfunction

        function void note_request(logic [1:0] mode, logic [POS_W-1:0] pos,
                                   logic [LEN_W-1:0] len);
            t_result     want;
            int unsigned start;
            want.status = ST_OK;
            want.found  = '0;
            start       = 0;
            case (mode)
                MODE_FREE: want.status = mark_run(pos, len, 1'b0);
                MODE_USED: want.status = mark_run(pos, len, 1'b1);
                MODE_FIND: begin
                    want.status = find_run(len, start);
                    if (want.status == ST_OK)
                        want.found = POS_W'(start);
                end
                default: ;
            endcase
            pending_results.push_back(want);
        endfunction

        function void check_result(logic [2:0] status, logic [POS_W-1:0] found);
            t_result want;
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: result with nothing pending: status %0d found_position %0d",
                             $time, status, found);
                return;
            end
            want = pending_results.pop_front();
            if (status !== want.status || found !== want.found) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: status exp %0d got %0d, found_position exp %0d got %0d",
                             $time, want.status, status, want.found, found);
            end
        endfunction
    endclass

    logic             i_clk = 1'b0;
    logic             i_rst_n;
    logic             i_in_valid;
    logic             o_in_ready;
    logic [1:0]       i_mode;
    logic [POS_W-1:0] i_position;
    logic [LEN_W-1:0] i_run_length;
    logic             o_out_valid;
    logic             i_out_ready;
    logic [2:0]       o_status;
    logic [POS_W-1:0] o_found_position;
    logic             psel;
    logic             penable;
    logic             pwrite;
    logic [2:0]       paddr;
    logic [31:0]      pwdata;
    logic [31:0]      prdata;
    logic             pready;

    alloc_scoreboard  sb = new();
    bit               steady = 1'b0;
    int unsigned      quiet_cycles = 0;

    bitmap_page_allocator_core uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_mode           (i_mode),
        .i_position       (i_position),
        .i_run_length     (i_run_length),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_status         (o_status),
        .o_found_position (o_found_position),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready)
    );

    always #(CLK_HALF) i_clk = ~i_clk;

    // transfer monitor and watchdog
    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && o_in_ready)
            sb.note_request(i_mode, i_position, i_run_length);
        if (i_rst_n && o_out_valid && i_out_ready)
            sb.check_result(o_status, o_found_position);
        if (i_rst_n && ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("bitmap_page_allocator_core test failed");
            $finish;
        end
    end

    // result side: random stall before each transfer
    initial begin : result_sink
        int unsigned hold;
        forever begin
            hold = steady ? 0 : $urandom_range(0, 7);
            @(negedge i_clk);
            if (hold != 0) begin
                i_out_ready <= 1'b0;
                repeat (hold) @(negedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
        end
    end

    // one request transfer, with a random gap ahead of it
    task automatic send_request(input logic [1:0] mode, input logic [POS_W-1:0] pos,
                                input logic [LEN_W-1:0] len);
        int unsigned gap;
        gap = steady ? 0 : $urandom_range(0, 7);
        @(negedge i_clk);
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_mode       <= mode;
        i_position   <= pos;
        i_run_length <= len;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(negedge i_clk);
    endtask

    task automatic write_tracked(input logic [ENT_W-1:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= TRACKED_ADDR;
        pwdata  <= 32'(value);
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.set_tracked(value);
    endtask

    // random request, mostly well-formed runs packed into a low window
    task automatic draw_request(input int unsigned window, output logic [1:0] mode,
                                output logic [POS_W-1:0] pos, output logic [LEN_W-1:0] len);
        int unsigned ent;
        int unsigned roll;
        int unsigned span;
        int unsigned top;
        int unsigned p;
        bit          aligned;
        ent     = sb.live_pages();
        roll    = $urandom_range(0, 99);
        aligned = 1'b0;
        if (roll < 8 || ent == 0) begin
            // noise: bad lengths, runs off the end, the unused kind
            case ($urandom_range(0, 3))
                0: mode = MODE_FREE;
                1: mode = MODE_USED;
                2: mode = MODE_FIND;
                default: mode = MODE_UNDEF;
            endcase
            pos = POS_W'($urandom);
            len = ($urandom_range(0, 2) == 0) ? '0 : LEN_W'($urandom);
        end else if (roll < 33) begin
            mode = MODE_FIND;
            pos  = POS_W'($urandom);
            case ($urandom_range(0, 9))
                0:       span = $urandom_range(1, ent);
                1, 2:    span = $urandom_range(33, 160);
                default: span = $urandom_range(1, 32);
            endcase
            len = LEN_W'(span);
        end else begin
            mode = ($urandom_range(0, 99) < 55) ? MODE_USED : MODE_FREE;
            case ($urandom_range(0, 19))
                0: span = $urandom_range(1, ent);
                1, 2, 3: begin
                    span    = WORD_BITS * $urandom_range(1, 4);
                    aligned = 1'b1;
                end
                default: span = $urandom_range(1, 40);
            endcase
            if (span > ent)
                span = ent;
            top = ent - span;
            if ($urandom_range(0, 3) == 0)
                p = $urandom_range(0, top);
            else
                p = $urandom_range(0, (top < window) ? top : window);
            if (aligned)
                p = p - p % WORD_BITS;
            pos = POS_W'(p);
            len = LEN_W'(span);
        end
    endtask

    initial begin : stimulus
        logic [1:0]       mode;
        logic [POS_W-1:0] pos;
        logic [LEN_W-1:0] len;
        int unsigned      pages;
        int unsigned      window;
        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_mode       = MODE_FREE;
        i_position   = '0;
        i_run_length = '0;
        i_out_ready  = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed requests at the reset page count
        send_request(MODE_FIND, 0, 1);
        send_request(MODE_FREE, 5, 0);
        send_request(MODE_USED, 5, 0);
        send_request(MODE_FIND, 5, 0);
        send_request(MODE_UNDEF, 15'h7FFF, 16'hFFFF);
        send_request(MODE_USED, 0, 32);
        send_request(MODE_FIND, 0, 1);
        send_request(MODE_USED, 32767, 1);
        send_request(MODE_USED, 32767, 2);
        send_request(MODE_FREE, 0, 16'hFFFF);
        send_request(MODE_USED, 10, 5);
        send_request(MODE_FREE, 40, 3);
        send_request(MODE_FREE, 10, 5);
        send_request(MODE_FIND, 0, 5);
        send_request(MODE_USED, 16384, 100);
        send_request(MODE_FIND, 0, 16'd32768);
        send_request(MODE_FREE, 0, 16'd32768);
        send_request(MODE_FIND, 15'h7FFF, 16'd32768);
        send_request(MODE_USED, 0, 16'd32768);
        send_request(MODE_FIND, 0, 1);
        send_request(MODE_FIND, 0, 1);
        send_request(MODE_FREE, 32767, 1);
        send_request(MODE_FIND, 0, 1);
        send_request(MODE_FREE, 0, 16'd32768);
        wait_drained();

        // random phases, each at its own page count
        for (int ph = 0; ph < PHASES; ph++) begin
            pages = (ph == 6) ? $urandom_range(2, 65535) : PHASE_PAGES[ph];
            write_tracked(ENT_W'(pages));
            steady = (ph % 3 == 1);
            window = $urandom_range(64, 1024);
            repeat (PHASE_ITEMS) begin
                draw_request(window, mode, pos, len);
                send_request(mode, pos, len);
                // now and then let the pipeline run dry
                if ($urandom_range(0, 39) == 0)
                    wait_drained();
            end
            wait_drained();
        end

        repeat (64) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("bitmap_page_allocator_core test passed");
        else
            $display("bitmap_page_allocator_core test failed");
        $finish;
    end

endmodule
